// ----- rtl/core/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg: box mean filter shared definitions
// Frame limits, field widths, register indexes and the request structs that
// pass between the sequencer, the line store and the divider.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_KERNEL = 15;
  localparam int STORE_ROWS = MAX_KERNEL - 1;

  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int WID_W   = 11;
  localparam int HGT_W   = 13;
  localparam int KER_W   = 4;
  localparam int CSUM_W  = 12;
  localparam int WSUM_W  = 16;
  localparam int AREA_W  = 8;

  localparam int SLOT_W    = $clog2(STORE_ROWS);
  localparam int LS_AW     = SLOT_W + COL_W;
  localparam int LS_DEPTH  = STORE_ROWS * MAX_WIDTH;
  localparam int DIV_CNT_W = $clog2(WSUM_W);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_KERNEL_HEIGHT = 2'd2,
    CFG_KERNEL_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             rd_en;
    logic [LS_AW-1:0] rd_addr;
    logic             wr_en;
    logic [LS_AW-1:0] wr_addr;
    logic [PIX_W-1:0] wr_data;
  } ls_req_t;

  typedef struct packed {
    logic              start;
    logic [WSUM_W-1:0] dividend;
    logic [AREA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WSUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/core/bmf_ifs.sv -----
// ----------------------------------------------------------------------------
// bmf_ifs: box mean filter stream channels
// Valid/ready channels for incoming pixels and outgoing window means.
// ----------------------------------------------------------------------------
interface bmf_in_if;
  logic                      valid;
  logic                      ready;
  logic [bmf_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [bmf_pkg::PIX_W-1:0] mean_value;
  logic [bmf_pkg::ROW_W-1:0] out_row;
  logic [bmf_pkg::COL_W-1:0] out_col;
  logic                      frame_last;

  modport source (output valid, output mean_value, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input mean_value, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

// ----- rtl/core/bmf_line_store.sv -----
// ----------------------------------------------------------------------------
// bmf_line_store: previous-row pixel memory
// STORE_ROWS rows of MAX_WIDTH pixels, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module bmf_line_store (
  input  logic                      clk,
  input  bmf_pkg::ls_req_t          req,
  output logic [bmf_pkg::PIX_W-1:0] rd_data
);

  logic [bmf_pkg::PIX_W-1:0] mem [bmf_pkg::LS_DEPTH];
  logic [bmf_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/bmf_divider.sv -----
// ----------------------------------------------------------------------------
// bmf_divider: radix-2 restoring divider
// One quotient bit per cycle, done pulses for one cycle.
// ----------------------------------------------------------------------------
module bmf_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  bmf_pkg::div_req_t req,
  output bmf_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [bmf_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [bmf_pkg::WSUM_W-1:0]        quo_r;
  logic [bmf_pkg::AREA_W-1:0]        rem_r;
  logic [bmf_pkg::AREA_W-1:0]        dsr_r;
  logic [bmf_pkg::AREA_W:0]          trial;
  logic [bmf_pkg::AREA_W:0]          diff;
  logic                              ge;

  // remainder stays below the divisor, so AREA_W bits hold it
  assign trial = {rem_r, quo_r[bmf_pkg::WSUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bmf_pkg::DIV_CNT_W'(bmf_pkg::WSUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[bmf_pkg::WSUM_W-2:0], ge};
      rem_r <= ge ? diff[bmf_pkg::AREA_W-1:0] : trial[bmf_pkg::AREA_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/core/box_mean_filter.sv -----
// ----------------------------------------------------------------------------
// box_mean_filter: streaming kh x kw box mean over raster-order grey pixels
// Column sums are rebuilt per pixel from a line store memory, summed across
// the window from a short column-sum shift line and divided by the area.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  in_if   | in  | valid / ready       | pixel[7:0]
//  out_if  | out | valid / ready       | mean_value[7:0] out_row[11:0]
//          |     |                     | out_col[9:0] frame_last
//  cfg_*   | in  | cfg_we (no stall)   | cfg_index[1:0] cfg_data[12:0]
//
// Sequence: a pixel at row r makes n = min(kh-1, r) line store reads and is
//   then written to the store; a pixel that yields a result then adds its kw
//   column sums one at a time, runs the divider and loads the result register.
//   The single line store read port, the serial window add and the one bit a
//   cycle divider set the pace.
// Reset: synchronous, active low; counters to the frame origin, registers to
//   1024 x 1024 with a 3 x 3 kernel. The line store is not cleared.
// Stalls: the result register holds one request; the next pixel is taken while
//   it waits, and the sequencer waits only when it has a second result to load.
// ----------------------------------------------------------------------------
module box_mean_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  bmf_in_if.sink                        in_if,
  bmf_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmf_pkg::CFG_DW-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WSUM = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  function automatic logic [bmf_pkg::SLOT_W-1:0] slot_inc(
    input logic [bmf_pkg::SLOT_W-1:0] s
  );
    return (s == bmf_pkg::SLOT_W'(bmf_pkg::STORE_ROWS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [bmf_pkg::SLOT_W-1:0] slot_dec(
    input logic [bmf_pkg::SLOT_W-1:0] s
  );
    return (s == '0) ? bmf_pkg::SLOT_W'(bmf_pkg::STORE_ROWS - 1) : s - 1'b1;
  endfunction

  // configuration, kept already clamped to the legal range
  logic [bmf_pkg::WID_W-1:0]  w_r;
  logic [bmf_pkg::HGT_W-1:0]  h_r;
  logic [bmf_pkg::KER_W-1:0]  kh_r;
  logic [bmf_pkg::KER_W-1:0]  kw_r;
  logic [bmf_pkg::WID_W-1:0]  cfg_w;
  logic [bmf_pkg::HGT_W-1:0]  cfg_h;
  logic [bmf_pkg::KER_W-1:0]  cfg_k;

  // raster position; slot_cnt_r tracks row_cnt_r modulo STORE_ROWS
  logic [bmf_pkg::ROW_W-1:0]  row_cnt_r;
  logic [bmf_pkg::COL_W-1:0]  col_cnt_r;
  logic [bmf_pkg::SLOT_W-1:0] slot_cnt_r;

  state_t                     state_r;
  state_t                     state_nxt;

  // current pixel
  logic [bmf_pkg::ROW_W-1:0]  pos_row_r;
  logic [bmf_pkg::COL_W-1:0]  pos_col_r;
  logic [bmf_pkg::SLOT_W-1:0] pos_slot_r;
  logic [bmf_pkg::PIX_W-1:0]  pix_r;
  logic [bmf_pkg::CSUM_W-1:0] csum_r;
  logic [bmf_pkg::KER_W-1:0]  rd_k_r;
  logic [bmf_pkg::SLOT_W-1:0] rd_slot_r;
  logic                       rd_vld_r;

  // column sums of the latest columns, newest in entry 0
  logic [bmf_pkg::CSUM_W-1:0] taps_r [bmf_pkg::MAX_KERNEL];
  logic [bmf_pkg::KER_W-1:0]  wk_r;
  logic [bmf_pkg::WSUM_W-1:0] wsum_r;
  logic [bmf_pkg::PIX_W-1:0]  mean_r;

  // result register
  logic                       out_valid_r;
  logic [bmf_pkg::PIX_W-1:0]  out_mean_r;
  logic [bmf_pkg::ROW_W-1:0]  out_row_r;
  logic [bmf_pkg::COL_W-1:0]  out_col_r;
  logic                       out_last_r;

  // position update
  logic                       accept;
  logic                       wrap_pre;
  logic [bmf_pkg::HGT_W-1:0]  row_inc_pre;
  logic [bmf_pkg::SLOT_W-1:0] slot_inc_pre;
  logic                       row_wrap_pre;
  logic [bmf_pkg::ROW_W-1:0]  row_fix;
  logic [bmf_pkg::COL_W-1:0]  col_fix;
  logic [bmf_pkg::SLOT_W-1:0] slot_fix;
  logic [bmf_pkg::WID_W-1:0]  col_plus;
  logic [bmf_pkg::HGT_W-1:0]  row_plus;
  logic                       wrap_post;
  logic                       row_wrap_post;
  logic [bmf_pkg::ROW_W-1:0]  row_cnt_nxt;
  logic [bmf_pkg::COL_W-1:0]  col_cnt_nxt;
  logic [bmf_pkg::SLOT_W-1:0] slot_cnt_nxt;

  // read sequencing and window test
  logic [bmf_pkg::KER_W-1:0]  kh_m1;
  logic [bmf_pkg::KER_W-1:0]  kw_m1;
  logic [bmf_pkg::KER_W-1:0]  nreads;
  logic                       issue;
  logic                       read_done;
  logic [bmf_pkg::ROW_W-1:0]  top;
  logic [bmf_pkg::COL_W-1:0]  left;
  logic [bmf_pkg::HGT_W-1:0]  top_end;
  logic [bmf_pkg::WID_W-1:0]  left_end;
  logic                       emit;
  logic                       last_pix;
  logic [bmf_pkg::WSUM_W-1:0] wsum_add;
  logic                       wsum_last;
  logic [bmf_pkg::AREA_W-1:0] area;
  logic                       out_free;
  logic                       out_load;

  bmf_pkg::ls_req_t           ls_req;
  logic [bmf_pkg::PIX_W-1:0]  ls_rd_data;
  bmf_pkg::div_req_t          div_req;
  bmf_pkg::div_rsp_t          div_rsp;

  // ---------------- configuration clamping ----------------
  always_comb begin
    cfg_w = cfg_data[bmf_pkg::WID_W-1:0];
    if (cfg_w == '0) begin
      cfg_w = bmf_pkg::WID_W'(1);
    end else if (cfg_w > bmf_pkg::WID_W'(bmf_pkg::MAX_WIDTH)) begin
      cfg_w = bmf_pkg::WID_W'(bmf_pkg::MAX_WIDTH);
    end
    cfg_h = cfg_data[bmf_pkg::HGT_W-1:0];
    if (cfg_h == '0) begin
      cfg_h = bmf_pkg::HGT_W'(1);
    end else if (cfg_h > bmf_pkg::HGT_W'(bmf_pkg::MAX_HEIGHT)) begin
      cfg_h = bmf_pkg::HGT_W'(bmf_pkg::MAX_HEIGHT);
    end
    cfg_k = cfg_data[bmf_pkg::KER_W-1:0];
    if (cfg_k == '0) begin
      cfg_k = bmf_pkg::KER_W'(1);
    end else if (cfg_k > bmf_pkg::KER_W'(bmf_pkg::MAX_KERNEL)) begin
      cfg_k = bmf_pkg::KER_W'(bmf_pkg::MAX_KERNEL);
    end
  end

  // ---------------- raster position ----------------
  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  // a register write may leave the counters past a shrunk frame: fold first
  always_comb begin
    wrap_pre     = {1'b0, col_cnt_r} >= w_r;
    row_inc_pre  = {1'b0, row_cnt_r} + bmf_pkg::HGT_W'(wrap_pre);
    slot_inc_pre = wrap_pre ? slot_inc(slot_cnt_r) : slot_cnt_r;
    row_wrap_pre = row_inc_pre >= h_r;
    row_fix      = row_wrap_pre ? '0 : row_inc_pre[bmf_pkg::ROW_W-1:0];
    slot_fix     = row_wrap_pre ? '0 : slot_inc_pre;
    col_fix      = wrap_pre ? '0 : col_cnt_r;

    col_plus      = {1'b0, col_fix} + 1'b1;
    row_plus      = {1'b0, row_fix} + 1'b1;
    wrap_post     = col_plus >= w_r;
    row_wrap_post = row_plus >= h_r;
    if (wrap_post) begin
      col_cnt_nxt  = '0;
      row_cnt_nxt  = row_wrap_post ? '0 : row_plus[bmf_pkg::ROW_W-1:0];
      slot_cnt_nxt = row_wrap_post ? '0 : slot_inc(slot_fix);
    end else begin
      col_cnt_nxt  = col_plus[bmf_pkg::COL_W-1:0];
      row_cnt_nxt  = row_fix;
      slot_cnt_nxt = slot_fix;
    end
  end

  // ---------------- line store reads ----------------
  // rows above that belong to this frame: min(kh-1, r)
  assign kh_m1  = kh_r - 1'b1;
  assign kw_m1  = kw_r - 1'b1;
  assign nreads = ({{(bmf_pkg::ROW_W-bmf_pkg::KER_W){1'b0}}, kh_m1} > pos_row_r) ?
                  pos_row_r[bmf_pkg::KER_W-1:0] : kh_m1;

  assign issue     = (state_r == S_READ) && (rd_k_r <= nreads);
  // all reads back: store this pixel last, the oldest row may share its slot
  assign read_done = (state_r == S_READ) && !issue && !rd_vld_r;

  always_comb begin
    ls_req.rd_en   = issue;
    ls_req.rd_addr = {rd_slot_r, pos_col_r};
    ls_req.wr_en   = read_done;
    ls_req.wr_addr = {pos_slot_r, pos_col_r};
    ls_req.wr_data = pix_r;
  end

  bmf_line_store u_line_store (
    .clk     (clk),
    .req     (ls_req),
    .rd_data (ls_rd_data)
  );

  // ---------------- window test ----------------
  // top + 2*(kh/2) + 1 <= h keeps the centre inside, same for columns
  always_comb begin
    top      = pos_row_r - bmf_pkg::ROW_W'(kh_m1);
    left     = pos_col_r - bmf_pkg::COL_W'(kw_m1);
    top_end  = {1'b0, top} + bmf_pkg::HGT_W'({kh_r[bmf_pkg::KER_W-1:1], 1'b0}) + 1'b1;
    left_end = {1'b0, left} + bmf_pkg::WID_W'({kw_r[bmf_pkg::KER_W-1:1], 1'b0}) + 1'b1;
    emit     = (pos_row_r >= bmf_pkg::ROW_W'(kh_m1)) &&
               (pos_col_r >= bmf_pkg::COL_W'(kw_m1)) &&
               (top_end <= h_r) && (left_end <= w_r);
    last_pix = (top_end == h_r) && (left_end == w_r);
  end

  // ---------------- window sum and divide ----------------
  assign wsum_add  = wsum_r + bmf_pkg::WSUM_W'(taps_r[wk_r]);
  assign wsum_last = (wk_r == kw_m1);
  assign area      = {{(bmf_pkg::AREA_W-bmf_pkg::KER_W){1'b0}}, kh_r} *
                     {{(bmf_pkg::AREA_W-bmf_pkg::KER_W){1'b0}}, kw_r};

  always_comb begin
    div_req.start    = (state_r == S_WSUM) && wsum_last;
    div_req.dividend = wsum_add;
    div_req.divisor  = area;
  end

  bmf_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------- result register ----------------
  assign out_free = !out_valid_r || out_if.ready;
  assign out_load = (state_r == S_OUT) && out_free;

  assign out_if.valid      = out_valid_r;
  assign out_if.mean_value = out_mean_r;
  assign out_if.out_row    = out_row_r;
  assign out_if.out_col    = out_col_r;
  assign out_if.frame_last = out_last_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        if (read_done) state_nxt = emit ? S_WSUM : S_IDLE;
      end
      S_WSUM: begin
        if (wsum_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      slot_cnt_r  <= '0;
      w_r         <= bmf_pkg::WID_W'(1024);
      h_r         <= bmf_pkg::HGT_W'(1024);
      kh_r        <= bmf_pkg::KER_W'(3);
      kw_r        <= bmf_pkg::KER_W'(3);
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        row_cnt_r  <= row_cnt_nxt;
        col_cnt_r  <= col_cnt_nxt;
        slot_cnt_r <= slot_cnt_nxt;
      end
      if (cfg_we) begin
        case (bmf_pkg::cfg_reg_t'(cfg_index))
          bmf_pkg::CFG_IMAGE_WIDTH:   w_r  <= cfg_w;
          bmf_pkg::CFG_IMAGE_HEIGHT:  h_r  <= cfg_h;
          bmf_pkg::CFG_KERNEL_HEIGHT: kh_r <= cfg_k;
          bmf_pkg::CFG_KERNEL_WIDTH:  kw_r <= cfg_k;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_row_r  <= row_fix;
      pos_col_r  <= col_fix;
      pos_slot_r <= slot_fix;
      pix_r      <= in_if.pixel;
      csum_r     <= bmf_pkg::CSUM_W'(in_if.pixel);
      rd_k_r     <= bmf_pkg::KER_W'(1);
      rd_slot_r  <= slot_dec(slot_fix);
    end
    if (issue) begin
      rd_k_r    <= rd_k_r + 1'b1;
      rd_slot_r <= slot_dec(rd_slot_r);
    end
    if (rd_vld_r) begin
      csum_r <= csum_r + bmf_pkg::CSUM_W'(ls_rd_data);
    end
    if (read_done) begin
      taps_r[0] <= csum_r;
      for (int i = 1; i < bmf_pkg::MAX_KERNEL; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
      wk_r   <= '0;
      wsum_r <= '0;
    end
    if ((state_r == S_WSUM) && !wsum_last) begin
      wk_r   <= wk_r + 1'b1;
      wsum_r <= wsum_add;
    end
    if ((state_r == S_DIV) && div_rsp.done) begin
      mean_r <= div_rsp.quotient[bmf_pkg::PIX_W-1:0];
    end
    if (out_load) begin
      out_mean_r <= mean_r;
      out_row_r  <= top;
      out_col_r  <= left;
      out_last_r <= last_pix;
    end
  end

  // ---------------- checks ----------------
  a_ls_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ls_req.wr_en |-> !ls_req.rd_en)
    else $error("line store write overlaps a read");

  a_rd_data_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_READ))
    else $error("line store data returned outside the read phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished while not awaited");

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: box_mean_filter stream checker
// Feeds raster-order pixel frames through the pixel channel, predicts every
// window mean from a cycle-free model of the filter kept in step with each
// accepted pixel, and checks each mean request on the result channel in order.
// Both sides stall at random; the register set changes between phases, and
// also once a frame has been cut short so that the counters wrap early.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmf_pkg::*;

  localparam int RANDOM_PIXELS  = 200;
  localparam int SETTLE_CYCLES  = 100;
  localparam int SQUEEZE_CYCLES = 600;
  localparam int DRAIN_LIMIT    = 50_000;
  localparam int CYCLE_LIMIT    = 4_000_000;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_last;
  } mean_result_t;

  typedef enum int {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_WALK, PIX_EDGES} pixel_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_data;

  bmf_in_if  pix_ch ();
  bmf_out_if mean_ch ();

  box_mean_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix_ch),
    .out_if    (mean_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the register file and of the filter's own state.
  logic [WID_W-1:0]  img_w_reg;
  logic [HGT_W-1:0]  img_h_reg;
  logic [KER_W-1:0]  ker_h_reg;
  logic [KER_W-1:0]  ker_w_reg;
  logic [PIX_W-1:0]  line_mem [LS_DEPTH];
  logic [CSUM_W-1:0] col_sum_mem [MAX_WIDTH];
  int                row_pos = 0;
  int                col_pos = 0;

  logic [PIX_W-1:0]  pixel_queue [$];      // pixels waiting for the driver
  mean_result_t      expected_means [$];   // predicted means, oldest first

  int pixels_offered = 0;
  int pixels_taken   = 0;
  int means_seen     = 0;
  int frames_closed  = 0;
  int cfg_writes     = 0;
  int random_pixels  = 0;
  int errors         = 0;
  int cycles         = 0;

  // Idle control for the two sides.
  int gap_left   = 0;
  int send_calm  = 0;
  int hold_left  = 0;
  int recv_calm  = 0;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Zero reads as one, anything past the top saturates.
  function automatic int eff_size(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with
  // no gaps at all.
  function automatic int idle_len(ref int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      calm = $urandom_range(40, 150);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(5, 15);
    return $urandom_range(20, 60);
  endfunction

  // Kernel sizes: mostly small so windows fit the small frames, sometimes any.
  function automatic int pick_kernel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(1, 5);
  endfunction

  // Pixels still to send until the raster counters are back at the origin.
  // At the origin this is one whole frame.
  function automatic int pixels_left_in_frame();
    int w, h, r, c;
    w = eff_size(int'(img_w_reg), MAX_WIDTH);
    h = eff_size(int'(img_h_reg), MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    return (h - r) * w - c;
  endfunction

  // Advance the model by one accepted pixel and queue the mean it yields.
  task automatic predict_pixel(input logic [PIX_W-1:0] p);
    int           w, h, kh, kw, r, c, k, last_top, last_left;
    int unsigned  col_total;
    int unsigned  win_total;
    mean_result_t res;
    w  = eff_size(int'(img_w_reg), MAX_WIDTH);
    h  = eff_size(int'(img_h_reg), MAX_HEIGHT);
    kh = eff_size(int'(ker_h_reg), MAX_KERNEL);
    kw = eff_size(int'(ker_w_reg), MAX_KERNEL);
    // counters may sit past a frame that shrank since the last pixel
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    r = row_pos;
    c = col_pos;

    // column sum over the rows of this frame inside the window
    col_total = p;
    for (k = 1; k < kh && k <= r; k++)
      col_total += line_mem[((r - k) % STORE_ROWS) * MAX_WIDTH + c];
    col_sum_mem[c] = CSUM_W'(col_total);
    line_mem[(r % STORE_ROWS) * MAX_WIDTH + c] = p;

    last_top  = h - 1 - 2 * (kh / 2);
    last_left = w - 1 - 2 * (kw / 2);
    if (r >= kh - 1 && c >= kw - 1 && r - (kh - 1) <= last_top &&
        c - (kw - 1) <= last_left) begin
      win_total = 0;
      for (k = 0; k < kw; k++) win_total += col_sum_mem[c - k];
      win_total = win_total & 32'hFFFF;
      res.mean_value = PIX_W'(win_total / (kh * kw));
      res.out_row    = ROW_W'(r - (kh - 1));
      res.out_col    = COL_W'(c - (kw - 1));
      res.frame_last = (r - (kh - 1) == last_top) && (c - (kw - 1) == last_left);
      expected_means.push_back(res);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Wait until the block has drained: no pixel left, no mean outstanding, and
  // time for a last pixel that gives no mean to work its way through.
  task automatic settle();
    while (pixel_queue.size() != 0 || pixels_taken != pixels_offered ||
           expected_means.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:   img_w_reg = WID_W'(val);
      CFG_IMAGE_HEIGHT:  img_h_reg = HGT_W'(val);
      CFG_KERNEL_HEIGHT: ker_h_reg = KER_W'(val);
      CFG_KERNEL_WIDTH:  ker_w_reg = KER_W'(val);
      default: ;
    endcase
    cfg_writes++;
  endtask

  // All four registers, only ever with the block idle.
  task automatic configure(input int w, input int h, input int kh, input int kw);
    settle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_KERNEL_HEIGHT, kh);
    write_reg(CFG_KERNEL_WIDTH, kw);
  endtask

  task automatic queue_pixels(input int n, input pixel_mode_t mode);
    int i;
    for (i = 0; i < n; i++) begin
      case (mode)
        PIX_WHITE: pixel_queue.push_back(8'hFF);
        PIX_BLACK: pixel_queue.push_back(8'h00);
        PIX_WALK:  pixel_queue.push_back((i % 9 == 8) ? 8'hFF : 8'(1 << (i % 8)));
        PIX_EDGES: begin
          case ($urandom_range(0, 2))
            0:       pixel_queue.push_back(8'h00);
            1:       pixel_queue.push_back(8'hFF);
            default: pixel_queue.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        default:   pixel_queue.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Pixel driver: offers the next queued pixel at the falling edge and holds
  // it until the posedge monitor below has seen the request taken.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && pixels_taken == pixels_offered) begin
      if (gap_left > 0) begin
        gap_left--;
        pix_ch.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pix_ch.pixel <= pixel_queue.pop_front();
        pix_ch.valid <= 1'b1;
        pixels_offered++;
        gap_left = idle_len(send_calm);
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // Accepted pixel requests drive the prediction.
  always @(posedge clk) begin
    if (rst_n && pix_ch.valid && pix_ch.ready) begin
      predict_pixel(pix_ch.pixel);
      pixels_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Mean receiver: random stalls, plus one long hold-off on request so that
  // the result side backs up into the pixel side.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        hold_left    = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        mean_ch.ready <= 1'b0;
      end else begin
        hold_left = idle_len(recv_calm);
        mean_ch.ready <= (hold_left == 0);
      end
    end
  end

  // Mean monitor: every accepted mean request against the oldest prediction.
  always @(posedge clk) begin : mean_monitor
    mean_result_t want;
    if (rst_n && mean_ch.valid && mean_ch.ready) begin
      means_seen++;
      if (mean_ch.frame_last) frames_closed++;
      if (expected_means.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected mean %0d row %0d col %0d last %0b", $time,
                 mean_ch.mean_value, mean_ch.out_row, mean_ch.out_col,
                 mean_ch.frame_last);
      end else begin
        want = expected_means.pop_front();
        if (mean_ch.mean_value !== want.mean_value || mean_ch.out_row !== want.out_row ||
            mean_ch.out_col !== want.out_col || mean_ch.frame_last !== want.frame_last)
        begin
          errors++;
          $display("%0t ns: mean mismatch: expected mean %0d row %0d col %0d last %0b",
                   $time, want.mean_value, want.out_row, want.out_col, want.frame_last);
          $display("%0t ns:                actual   mean %0d row %0d col %0d last %0b",
                   $time, mean_ch.mean_value, mean_ch.out_row, mean_ch.out_col,
                   mean_ch.frame_last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: run stuck after %0d cycles", $time, cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int i, n, w, h, nw;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    pix_ch.valid  = 1'b0;
    pix_ch.pixel  = '0;
    mean_ch.ready = 1'b0;
    // reset state of the shadow: 1024 x 1024 frame, 3 x 3 kernel
    img_w_reg = WID_W'(1024);
    img_h_reg = HGT_W'(1024);
    ker_h_reg = KER_W'(3);
    ker_w_reg = KER_W'(3);
    for (i = 0; i < LS_DEPTH; i++) line_mem[i] = '0;
    for (i = 0; i < MAX_WIDTH; i++) col_sum_mem[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero registers read as one: two 1 x 1 frames, each its own mean.
    configure(0, 0, 0, 0);
    queue_pixels(1, PIX_BLACK);
    queue_pixels(1, PIX_WHITE);

    // Uneven kernel on a small frame, walking-one pixels.
    configure(4, 3, 3, 2);
    queue_pixels(12, PIX_WALK);

    // Kernel larger than the frame: nothing comes out.
    configure(3, 2, 15, 15);
    queue_pixels(6, PIX_WHITE);

    // Largest window, all white: widest column and window sums.
    configure(15, 15, 15, 15);
    queue_pixels(225, PIX_WHITE);

    // Width past the top saturates at the line length; the receiver holds off
    // for a long stretch here so the input side has to stall.
    configure(2047, 1, 1, 15);
    squeeze_req = 1'b1;
    queue_pixels(MAX_WIDTH, PIX_RANDOM);

    // Height past the top saturates: one column, the top of a tall frame, then
    // a short frame folds the counters back to the origin.
    configure(1, 8191, 4, 1);
    queue_pixels(64, PIX_EDGES);
    configure(1, 2, 1, 1);
    queue_pixels(pixels_left_in_frame(), PIX_EDGES);

    // Frame cut short: width and height shrink under the counters, both wrap.
    configure(8, 6, 3, 3);
    queue_pixels(21, PIX_RANDOM);
    configure(4, 3, 2, 3);
    queue_pixels(pixels_left_in_frame(), PIX_RANDOM);

    // Height shrinks mid-frame, column carries on in the new first row.
    configure(6, 8, 2, 2);
    queue_pixels(32, PIX_RANDOM);
    configure(6, 4, 3, 2);
    queue_pixels(pixels_left_in_frame(), PIX_EDGES);

    // Random phases: whole frames under random small settings, and now and
    // then a frame cut short by a narrower setting.
    while (random_pixels < RANDOM_PIXELS) begin
      configure($urandom_range(0, 20), $urandom_range(0, 12), pick_kernel(), pick_kernel());
      w = eff_size(int'(img_w_reg), MAX_WIDTH);
      h = eff_size(int'(img_h_reg), MAX_HEIGHT);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, w * h - 1);
        queue_pixels(n, pixel_mode_t'($urandom_range(0, 4)));
        random_pixels += n;
        // never wider lines, so every stored pixel read was written
        nw = $urandom_range(0, w);
        configure(nw, $urandom_range(0, 12), pick_kernel(), pick_kernel());
        n = pixels_left_in_frame();
      end else begin
        n = w * h * $urandom_range(1, 3);
      end
      queue_pixels(n, ($urandom_range(0, 3) == 0) ? pixel_mode_t'($urandom_range(1, 4))
                                                  : PIX_RANDOM);
      random_pixels += n;
    end

    // Wind down: all pixels in, then the means still owed, then a quiet tail.
    while (pixel_queue.size() != 0 || pixels_taken != pixels_offered) @(posedge clk);
    n = 0;
    while (expected_means.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_means.size() != 0) begin
      errors += expected_means.size();
      $display("%0t ns: %0d predicted means never arrived", $time,
               expected_means.size());
    end

    $display("box mean run: %0d pixels in, %0d means checked, %0d frames closed",
             pixels_taken, means_seen, frames_closed);
    $display("box mean run: %0d register writes, %0d errors", cfg_writes, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
